@@ hdl/link_turn_handshake_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the link turn handshake core
// Clocked implication checks with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef LINK_TURN_HANDSHAKE_CORE_ASSERT_SVH
`define LINK_TURN_HANDSHAKE_CORE_ASSERT_SVH

// same-cycle implication
`define LTH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lth assertion failed");

// next-cycle implication
`define LTH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lth assertion failed");

`endif

@@ hdl/lth_pkg.sv @@
// ----------------------------------------------------------------------------
// lth_pkg
// Types, codes and constants shared by the link turn handshake core.
// ----------------------------------------------------------------------------
package lth_pkg;

    localparam int unsigned NUM_WORDS = 8;

    typedef logic [NUM_WORDS-1:0][15:0] t_peer;
    typedef logic [NUM_WORDS-1:0][7:0]  t_rec;

    typedef logic [1:0] t_status;
    localparam t_status ST_IDLE = 2'd0;
    localparam t_status ST_WAIT = 2'd1;
    localparam t_status ST_OK   = 2'd2;
    localparam t_status ST_FAIL = 2'd3;

    typedef logic [2:0] t_stage;
    localparam t_stage STG_IDLE = 3'd0;
    localparam t_stage STG_1    = 3'd1;
    localparam t_stage STG_2    = 3'd2;
    localparam t_stage STG_3    = 3'd3;
    localparam t_stage STG_4    = 3'd4;
    localparam t_stage STG_5    = 3'd5;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_FRAME = 1'b1;

    typedef logic t_cfg_idx;
    localparam t_cfg_idx CFG_LINK_ENABLED = 1'b0;
    localparam t_cfg_idx CFG_MISS_LIMIT   = 1'b1;

    localparam logic [7:0] MISS_LIMIT_RST = 8'd24;
    localparam logic [7:0] MISS_MAX       = 8'd255;

    localparam logic [7:0] CH_LO_E = 8'h65;
    localparam logic [7:0] CH_LO_X = 8'h78;
    localparam logic [7:0] CH_LO_R = 8'h72;
    localparam logic [7:0] CH_LO_N = 8'h6E;
    localparam logic [7:0] CH_LO_T = 8'h74;
    localparam logic [7:0] CH_LO_U = 8'h75;
    localparam logic [7:0] CH_UP_T = 8'h54;
    localparam logic [7:0] CH_UP_U = 8'h55;
    localparam logic [7:0] CH_UP_E = 8'h45;
    localparam logic [7:0] CH_UP_X = 8'h58;
    localparam logic [7:0] CH_UP_C = 8'h43;
    localparam logic [7:0] CH_UP_R = 8'h52;
    localparam logic [7:0] CH_UP_N = 8'h4E;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic run_needed;
        logic step_done;
    } t_sts;

endpackage

@@ hdl/lth_if.sv @@
// ----------------------------------------------------------------------------
// lth_in_if / lth_out_if
// Valid/ready channels for frame items and handshake results.
// ----------------------------------------------------------------------------
interface lth_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic        paused;
    logic        link_ok;
    logic [15:0] peer_w0;
    logic [15:0] peer_w1;
    logic [15:0] peer_w2;
    logic [15:0] peer_w3;
    logic [15:0] peer_w4;
    logic [15:0] peer_w5;
    logic [15:0] peer_w6;
    logic [15:0] peer_w7;

    modport source (
        output valid, func, paused, link_ok,
        output peer_w0, peer_w1, peer_w2, peer_w3, peer_w4, peer_w5, peer_w6, peer_w7,
        input  ready
    );
    modport sink (
        input  valid, func, paused, link_ok,
        input  peer_w0, peer_w1, peer_w2, peer_w3, peer_w4, peer_w5, peer_w6, peer_w7,
        output ready
    );
endinterface

interface lth_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] stage_now;
    logic [7:0] local_w0;
    logic [7:0] local_w1;
    logic [7:0] local_w2;
    logic [7:0] local_w3;
    logic [7:0] local_w4;
    logic [7:0] local_w5;
    logic [7:0] local_w6;
    logic [7:0] local_w7;

    modport source (
        output valid, status, stage_now,
        output local_w0, local_w1, local_w2, local_w3,
        output local_w4, local_w5, local_w6, local_w7,
        input  ready
    );
    modport sink (
        input  valid, status, stage_now,
        input  local_w0, local_w1, local_w2, local_w3,
        input  local_w4, local_w5, local_w6, local_w7,
        output ready
    );
endinterface

@@ hdl/link_turn_handshake_core.sv @@
// ----------------------------------------------------------------------------
// link_turn_handshake_core
// Five-stage echo handshake that opens a linked turn.
// ----------------------------------------------------------------------------
// One result per accepted transaction. A start, a frame while idle and a
// frame without a complete transfer reach the result register in the cycle
// after acceptance. A frame with a complete transfer runs through k stage
// checks, where k is 1 to 5, before its result is set; the single shared
// stage-check unit evaluates one stage per cycle. The result is held until
// taken, and the next transaction is accepted the cycle after that.
// Configuration writes are taken at any time but belong between transactions.
module link_turn_handshake_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  lth_pkg::t_cfg_idx i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    lth_in_if.sink            i_req,
    lth_out_if.source         o_rsp
);

    lth_pkg::t_cmd    w_cmd;
    lth_pkg::t_sts    w_sts;
    lth_pkg::t_peer   w_peer;
    lth_pkg::t_rec    w_rec;
    lth_pkg::t_status w_status;
    lth_pkg::t_stage  w_stage;

    assign w_peer = {i_req.peer_w7, i_req.peer_w6, i_req.peer_w5, i_req.peer_w4,
                     i_req.peer_w3, i_req.peer_w2, i_req.peer_w1, i_req.peer_w0};

    lth_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    lth_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_func      (i_req.func),
        .i_paused    (i_req.paused),
        .i_link_ok   (i_req.link_ok),
        .i_peer      (w_peer),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_status    (w_status),
        .o_stage     (w_stage),
        .o_rec       (w_rec)
    );

    assign o_rsp.status    = w_status;
    assign o_rsp.stage_now = w_stage;
    assign o_rsp.local_w0  = w_rec[0];
    assign o_rsp.local_w1  = w_rec[1];
    assign o_rsp.local_w2  = w_rec[2];
    assign o_rsp.local_w3  = w_rec[3];
    assign o_rsp.local_w4  = w_rec[4];
    assign o_rsp.local_w5  = w_rec[5];
    assign o_rsp.local_w6  = w_rec[6];
    assign o_rsp.local_w7  = w_rec[7];

endmodule

@@ hdl/lth_ctrl.sv @@
// ----------------------------------------------------------------------------
// lth_ctrl
// Sequencer: accepts a transaction, steps the stage checks, presents the result.
// ----------------------------------------------------------------------------
module lth_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lth_pkg::t_cmd o_cmd,
    input  lth_pkg::t_sts i_sts
);

    lth_pkg::t_state r_state;
    lth_pkg::t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            lth_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.run_needed ? lth_pkg::S_RUN : lth_pkg::S_OUT;
                end
            end
            lth_pkg::S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.step_done) begin
                    n_state = lth_pkg::S_OUT;
                end
            end
            lth_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = lth_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lth_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lth_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/lth_dpath.sv @@
// ----------------------------------------------------------------------------
// lth_dpath
// Local record, stage, miss counter, configuration and one stage check a cycle.
// ----------------------------------------------------------------------------
module lth_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  lth_pkg::t_cfg_idx i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_func,
    input  logic              i_paused,
    input  logic              i_link_ok,
    input  lth_pkg::t_peer    i_peer,
    input  lth_pkg::t_cmd     i_cmd,
    output lth_pkg::t_sts     o_sts,
    output lth_pkg::t_status  o_status,
    output lth_pkg::t_stage   o_stage,
    output lth_pkg::t_rec     o_rec
);

    logic              r_link_en;
    logic [7:0]        r_miss_limit;
    lth_pkg::t_rec     r_rec;
    lth_pkg::t_rec     n_rec;
    lth_pkg::t_stage   r_stage;
    lth_pkg::t_stage   n_stage;
    logic [7:0]        r_miss;
    logic [7:0]        n_miss;
    lth_pkg::t_status  r_status;
    lth_pkg::t_status  n_status;
    lth_pkg::t_peer    r_peer;

    logic [lth_pkg::NUM_WORDS-1:0] w_same;
    logic [7:0]                    w_miss_inc;
    logic                          w_step_done;

    always_comb begin
        for (int i = 0; i < lth_pkg::NUM_WORDS; i++) begin
            w_same[i] = ({8'd0, r_rec[i]} == r_peer[i]);
        end
    end

    assign w_miss_inc = (r_miss == lth_pkg::MISS_MAX) ? r_miss : r_miss + 8'd1;

    assign o_sts.run_needed = (i_func == lth_pkg::FUNC_FRAME) && i_link_ok
                              && (r_stage != lth_pkg::STG_IDLE);
    assign o_sts.step_done  = w_step_done;

    always_comb begin
        n_rec       = r_rec;
        n_stage     = r_stage;
        n_miss      = r_miss;
        n_status    = r_status;
        w_step_done = 1'b1;
        if (i_cmd.load) begin
            if (i_func == lth_pkg::FUNC_START) begin
                n_miss  = '0;
                n_stage = lth_pkg::STG_IDLE;
                if (!r_link_en) begin
                    n_status = lth_pkg::ST_OK;
                end else if (i_paused) begin
                    n_status = lth_pkg::ST_FAIL;
                end else begin
                    n_rec[0] = lth_pkg::CH_LO_E;
                    n_rec[1] = lth_pkg::CH_LO_X;
                    n_rec[4] = lth_pkg::CH_UP_T;
                    n_rec[5] = lth_pkg::CH_UP_U;
                    n_stage  = lth_pkg::STG_1;
                    n_status = lth_pkg::ST_WAIT;
                end
            end else if (r_stage == lth_pkg::STG_IDLE) begin
                n_status = lth_pkg::ST_IDLE;
            end else if (!i_link_ok) begin
                n_miss = w_miss_inc;
                if (w_miss_inc > r_miss_limit) begin
                    n_status = lth_pkg::ST_FAIL;
                    n_stage  = lth_pkg::STG_IDLE;
                end else begin
                    n_status = lth_pkg::ST_WAIT;
                end
            end else begin
                n_miss   = '0;
                n_status = lth_pkg::ST_WAIT;
            end
        end else if (i_cmd.step) begin
            case (r_stage)
                lth_pkg::STG_1: begin
                    if (!(w_same[2] && w_same[3])) begin
                        n_status = lth_pkg::ST_FAIL;
                    end else if (!(w_same[0] && w_same[1] && w_same[4] && w_same[5])) begin
                        n_status = lth_pkg::ST_WAIT;
                    end else begin
                        n_rec[6]    = lth_pkg::CH_LO_R;
                        n_rec[7]    = lth_pkg::CH_LO_N;
                        n_stage     = lth_pkg::STG_2;
                        w_step_done = 1'b0;
                    end
                end
                lth_pkg::STG_2: begin
                    if (!(w_same[4] && w_same[5])) begin
                        n_status = lth_pkg::ST_FAIL;
                    end else if (!(w_same[6] && w_same[7])) begin
                        n_status = lth_pkg::ST_WAIT;
                    end else begin
                        n_rec[0]    = lth_pkg::CH_UP_E;
                        n_rec[1]    = lth_pkg::CH_UP_X;
                        n_rec[2]    = lth_pkg::CH_UP_E;
                        n_rec[3]    = lth_pkg::CH_UP_C;
                        n_stage     = lth_pkg::STG_3;
                        w_step_done = 1'b0;
                    end
                end
                lth_pkg::STG_3: begin
                    if (!(w_same[6] && w_same[7])) begin
                        n_status = lth_pkg::ST_FAIL;
                    end else if (!(w_same[0] && w_same[1] && w_same[2] && w_same[3])) begin
                        n_status = lth_pkg::ST_WAIT;
                    end else begin
                        n_rec[4]    = lth_pkg::CH_LO_T;
                        n_rec[5]    = lth_pkg::CH_LO_U;
                        n_stage     = lth_pkg::STG_4;
                        w_step_done = 1'b0;
                    end
                end
                lth_pkg::STG_4: begin
                    if (!(w_same[0] && w_same[1] && w_same[2] && w_same[3])) begin
                        n_status = lth_pkg::ST_FAIL;
                    end else if (!(w_same[4] && w_same[5])) begin
                        n_status = lth_pkg::ST_WAIT;
                    end else begin
                        n_rec[6]    = lth_pkg::CH_UP_R;
                        n_rec[7]    = lth_pkg::CH_UP_N;
                        n_stage     = lth_pkg::STG_5;
                        w_step_done = 1'b0;
                    end
                end
                lth_pkg::STG_5: begin
                    if ((r_peer[6] == {8'd0, lth_pkg::CH_LO_R})
                        && (r_peer[7] == {8'd0, lth_pkg::CH_LO_N})) begin
                        n_status = lth_pkg::ST_WAIT;
                    end else begin
                        n_status = lth_pkg::ST_OK;
                    end
                end
                default: begin
                    n_status = lth_pkg::ST_IDLE;
                end
            endcase
            if (w_step_done && (n_status != lth_pkg::ST_WAIT)) begin
                n_stage = lth_pkg::STG_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_en    <= 1'b0;
            r_miss_limit <= lth_pkg::MISS_LIMIT_RST;
            r_rec        <= '0;
            r_stage      <= lth_pkg::STG_IDLE;
            r_miss       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    lth_pkg::CFG_LINK_ENABLED: r_link_en    <= i_cfg_data[0];
                    lth_pkg::CFG_MISS_LIMIT:   r_miss_limit <= i_cfg_data;
                    default:                   r_link_en    <= r_link_en;
                endcase
            end
            r_rec   <= n_rec;
            r_stage <= n_stage;
            r_miss  <= n_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (i_cmd.load) begin
            r_peer <= i_peer;
        end
    end

    assign o_status = r_status;
    assign o_stage  = r_stage;
    assign o_rec    = r_rec;

endmodule

@@ hdl/lth_checker.sv @@
// ----------------------------------------------------------------------------
// lth_checker
// Port-level checks of the link turn handshake core, bound to the top level.
// ----------------------------------------------------------------------------
`include "link_turn_handshake_core_assert.svh"

module lth_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_status,
    input logic [2:0] i_stage
);

    `LTH_ASSERT_SAME(a_no_accept_while_pending, i_clk, i_rst_n, i_out_valid, !i_in_ready)
    `LTH_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `LTH_ASSERT_SAME(a_end_clears_stage, i_clk, i_rst_n,
        i_out_valid && (i_status != lth_pkg::ST_WAIT),
        i_stage == lth_pkg::STG_IDLE)
    `LTH_ASSERT_SAME(a_wait_has_stage, i_clk, i_rst_n,
        i_out_valid && (i_status == lth_pkg::ST_WAIT),
        (i_stage != lth_pkg::STG_IDLE) && (i_stage <= lth_pkg::STG_5))

endmodule

bind link_turn_handshake_core lth_checker u_lth_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_stage     (o_rsp.stage_now)
);
